// File: rtl/drhdc_pkg.sv
// Shared types and constants for the dual radio hop diversity controller.
package drhdc_pkg;

  localparam int CHANNELS_DEF = 32;

  localparam logic [4:0] TOP_CHANNEL_RST = 5'd30;
  localparam logic [7:0] RADIO_A_RST     = 8'd1;
  localparam logic [7:0] RADIO_B_RST     = 8'd2;
  localparam logic [7:0] SEQ_LAST        = 8'd255;
  localparam logic [6:0] SEARCH_LAST     = 7'd127;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_DIVERSITY = 3'd0,
    REG_HOPPING   = 3'd1,
    REG_START     = 3'd2,
    REG_TOP       = 3'd3,
    REG_CODE_A    = 3'd4,
    REG_CODE_B    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic       diversity_on;
    logic       hopping_on;
    logic       start_radio;
    logic [4:0] top_channel;
    logic [7:0] radio_a_code;
    logic [7:0] radio_b_code;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic ping_ok;
  } in_t;

  typedef struct packed {
    logic [7:0] next_radio_code;
    logic [7:0] next_sequence;
    logic [4:0] next_channel;
    logic       tune_radio;
    logic [4:0] tune_channel;
    logic       channel_flagged;
    logic [4:0] flagged_channel;
    logic       tally_done;
    logic [8:0] tally_failures;
    logic       exhausted;
  } out_t;

  typedef struct packed {
    logic accept;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic search_active;
    logic out_busy;
  } stat_t;

endpackage

// File: rtl/drhdc_regs.sv
// Configuration register file behind the APB-style port.
module drhdc_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [drhdc_pkg::ADDR_W-1:0] paddr,
  input  logic [drhdc_pkg::DATA_W-1:0] pwdata,
  output logic [drhdc_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output drhdc_pkg::cfg_t              cfg
);
  import drhdc_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diversity_on <= 1'b0;
      cfg.hopping_on   <= 1'b0;
      cfg.start_radio  <= 1'b0;
      cfg.top_channel  <= TOP_CHANNEL_RST;
      cfg.radio_a_code <= RADIO_A_RST;
      cfg.radio_b_code <= RADIO_B_RST;
    end else if (wr) begin
      unique case (idx)
        REG_DIVERSITY: cfg.diversity_on <= pwdata[0];
        REG_HOPPING:   cfg.hopping_on   <= pwdata[0];
        REG_START:     cfg.start_radio  <= pwdata[0];
        REG_TOP:       cfg.top_channel  <= pwdata[4:0];
        REG_CODE_A:    cfg.radio_a_code <= pwdata[7:0];
        REG_CODE_B:    cfg.radio_b_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DIVERSITY: prdata[0]   = cfg.diversity_on;
      REG_HOPPING:   prdata[0]   = cfg.hopping_on;
      REG_START:     prdata[0]   = cfg.start_radio;
      REG_TOP:       prdata[4:0] = cfg.top_channel;
      REG_CODE_A:    prdata[7:0] = cfg.radio_a_code;
      REG_CODE_B:    prdata[7:0] = cfg.radio_b_code;
      default: ;
    endcase
  end

endmodule

// File: rtl/drhdc_ctrl.sv
// Sequencing state machine: accept, hop search steps, result load.
module drhdc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  drhdc_pkg::stat_t stat,
  output drhdc_pkg::cmd_t  cmd
);
  import drhdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_active) begin
          cmd.step = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/drhdc_dp.sv
// Datapath: session state, channel good maps, hop search unit, result register.
module drhdc_dp #(
  parameter int CHANNELS = drhdc_pkg::CHANNELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  drhdc_pkg::cfg_t  cfg,
  input  drhdc_pkg::in_t   in_data,
  input  drhdc_pkg::cmd_t  cmd,
  output drhdc_pkg::stat_t stat,
  output logic             out_valid,
  input  logic             out_stall,
  output drhdc_pkg::out_t  out_data
);
  import drhdc_pkg::*;

  localparam int         IW       = $clog2(CHANNELS);
  localparam logic [8:0] CHAN_LIM = 9'(CHANNELS);

  logic                live_radio, live_radio_next;
  logic [4:0]          live_channel, live_channel_next;
  logic                announced, announced_next;
  logic [4:0]          pos_a, pos_a_next;
  logic [4:0]          pos_b, pos_b_next;
  logic                sweep_down, sweep_down_next;
  logic [7:0]          seq_count, seq_count_next;
  logic [8:0]          fail_count, fail_count_next;
  logic [4:0]          usable_a, usable_a_next;
  logic [4:0]          usable_b, usable_b_next;
  logic                halted, halted_next;
  logic [CHANNELS-1:0] good_a, good_a_next;
  logic [CHANNELS-1:0] good_b, good_b_next;
  logic                search_active, search_active_next;
  logic [6:0]          search_cnt, search_cnt_next;
  logic                flagged, flagged_next;
  logic [4:0]          flag_ch, flag_ch_next;
  logic                done, done_next;
  logic [8:0]          tally, tally_next;

  logic [4:0] step_pos;
  logic       step_good;
  logic       live_in_range;

  assign live_in_range = ({4'd0, live_channel} < CHAN_LIM);

  always_comb begin
    live_radio_next    = live_radio;
    live_channel_next  = live_channel;
    announced_next     = announced;
    pos_a_next         = pos_a;
    pos_b_next         = pos_b;
    sweep_down_next    = sweep_down;
    seq_count_next     = seq_count;
    fail_count_next    = fail_count;
    usable_a_next      = usable_a;
    usable_b_next      = usable_b;
    halted_next        = halted;
    good_a_next        = good_a;
    good_b_next        = good_b;
    search_active_next = search_active;
    search_cnt_next    = search_cnt;
    flagged_next       = flagged;
    flag_ch_next       = flag_ch;
    done_next          = done;
    tally_next         = tally;
    step_pos           = 5'd0;
    step_good          = 1'b1;

    if (cmd.accept) begin
      flagged_next       = 1'b0;
      flag_ch_next       = 5'd0;
      done_next          = 1'b0;
      tally_next         = 9'd0;
      search_cnt_next    = 7'd0;
      search_active_next = 1'b0;
      if (!in_data.mode) begin
        live_radio_next   = 1'b0;
        live_channel_next = 5'd0;
        announced_next    = cfg.start_radio;
        pos_a_next        = 5'd0;
        pos_b_next        = 5'd0;
        sweep_down_next   = 1'b0;
        seq_count_next    = 8'd0;
        fail_count_next   = 9'd0;
        usable_a_next     = cfg.top_channel;
        usable_b_next     = cfg.top_channel;
        halted_next       = 1'b0;
        good_a_next       = '1;
        good_b_next       = '1;
      end else if (!halted) begin
        if (in_data.ping_ok) begin
          live_radio_next    = announced;
          live_channel_next  = announced ? pos_b : pos_a;
          announced_next     = cfg.diversity_on ? ~announced : announced;
          search_active_next = cfg.hopping_on;
        end else begin
          fail_count_next = fail_count + 9'd1;
          if (live_channel != 5'd0 && cfg.hopping_on) begin
            flagged_next = 1'b1;
            flag_ch_next = live_channel;
            if (!live_radio) begin
              if (live_in_range) good_a_next[IW'(live_channel)] = 1'b0;
              if (usable_a > 5'd1) usable_a_next = usable_a - 5'd1;
              else                 halted_next   = 1'b1;
            end else begin
              if (live_in_range) good_b_next[IW'(live_channel)] = 1'b0;
              if (usable_b > 5'd1) usable_b_next = usable_b - 5'd1;
              else                 halted_next   = 1'b1;
            end
          end
          if (cfg.diversity_on || cfg.hopping_on || live_radio) begin
            announced_next    = cfg.start_radio;
            live_radio_next   = 1'b0;
            live_channel_next = 5'd0;
            pos_a_next        = 5'd0;
            pos_b_next        = 5'd0;
          end
        end
        // tally closes on the failure count including this item
        if (seq_count != SEQ_LAST) begin
          seq_count_next = seq_count + 8'd1;
        end else begin
          done_next       = 1'b1;
          tally_next      = fail_count_next;
          seq_count_next  = 8'd0;
          fail_count_next = 9'd0;
        end
      end
    end else if (cmd.step) begin
      // one hop of the announced radio per cycle
      if (!announced) begin
        if (!sweep_down) begin
          if (pos_a >= cfg.top_channel) begin
            sweep_down_next = 1'b1;
            step_pos        = pos_a;
          end else begin
            step_pos = pos_a + 5'd1;
          end
        end else begin
          if (pos_a == 5'd0) begin
            sweep_down_next = 1'b0;
            step_pos        = pos_a;
          end else begin
            step_pos = pos_a - 5'd1;
          end
        end
        pos_a_next = step_pos;
        step_good  = ({4'd0, step_pos} < CHAN_LIM) ? good_a[IW'(step_pos)] : 1'b1;
      end else begin
        step_pos   = (pos_b >= cfg.top_channel) ? 5'd0 : pos_b + 5'd1;
        pos_b_next = step_pos;
        step_good  = ({4'd0, step_pos} < CHAN_LIM) ? good_b[IW'(step_pos)] : 1'b1;
      end
      search_cnt_next    = search_cnt + 7'd1;
      search_active_next = !step_good && (search_cnt != SEARCH_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_radio    <= 1'b0;
      live_channel  <= 5'd0;
      announced     <= 1'b0;
      pos_a         <= 5'd0;
      pos_b         <= 5'd0;
      sweep_down    <= 1'b0;
      seq_count     <= 8'd0;
      fail_count    <= 9'd0;
      usable_a      <= TOP_CHANNEL_RST;
      usable_b      <= TOP_CHANNEL_RST;
      halted        <= 1'b0;
      good_a        <= '1;
      good_b        <= '1;
      search_active <= 1'b0;
      search_cnt    <= 7'd0;
      flagged       <= 1'b0;
      flag_ch       <= 5'd0;
      done          <= 1'b0;
      tally         <= 9'd0;
    end else begin
      live_radio    <= live_radio_next;
      live_channel  <= live_channel_next;
      announced     <= announced_next;
      pos_a         <= pos_a_next;
      pos_b         <= pos_b_next;
      sweep_down    <= sweep_down_next;
      seq_count     <= seq_count_next;
      fail_count    <= fail_count_next;
      usable_a      <= usable_a_next;
      usable_b      <= usable_b_next;
      halted        <= halted_next;
      good_a        <= good_a_next;
      good_b        <= good_b_next;
      search_active <= search_active_next;
      search_cnt    <= search_cnt_next;
      flagged       <= flagged_next;
      flag_ch       <= flag_ch_next;
      done          <= done_next;
      tally         <= tally_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.next_radio_code <= announced ? cfg.radio_b_code : cfg.radio_a_code;
      out_data.next_sequence   <= seq_count;
      out_data.next_channel    <= announced ? pos_b : pos_a;
      out_data.tune_radio      <= live_radio;
      out_data.tune_channel    <= live_channel;
      out_data.channel_flagged <= flagged;
      out_data.flagged_channel <= flag_ch;
      out_data.tally_done      <= done;
      out_data.tally_failures  <= tally;
      out_data.exhausted       <= halted;
    end
  end

  assign stat.search_active = search_active;
  assign stat.out_busy      = out_valid && out_stall;

endmodule

// File: rtl/dual_radio_hop_diversity_controller.sv
// Top level of the dual radio hop diversity controller.
//
// Input channel (in_valid / in_stall / in_data): one request per ping outcome
// or session start. Output channel (out_valid / out_stall / out_data): one
// header and tuning result per request, in order.
// Configuration must be written over the APB-style port only while the block
// is idle (not enforced here); registers sit at byte addresses 0 to 20, step 4.
// A request is taken only while the sequencer is idle. After a ping that needs
// a hop, the search unit moves the announced radio one channel per cycle until
// it finds a good one or gives up after 128 steps. The sequencer then passes
// from search to finish, loads the result into the output register and goes
// back to idle, where the next request is taken.
// If the receiver stalls, the result holds in the output register and the
// next request can still be accepted and processed; its result waits until
// the register frees up.
// Reset (rst, synchronous) restores the register defaults and starts a fresh
// session with every channel marked good; a start request does the same to
// the session state.
module dual_radio_hop_diversity_controller #(
  parameter int CHANNELS = drhdc_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  drhdc_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output drhdc_pkg::out_t              out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [drhdc_pkg::ADDR_W-1:0] paddr,
  input  logic [drhdc_pkg::DATA_W-1:0] pwdata,
  output logic [drhdc_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import drhdc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  drhdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drhdc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  drhdc_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: dv/tb_dual_radio_hop_diversity_controller.sv
// Testbench for the dual radio hop diversity controller with a cycle-free model.
module tb_dual_radio_hop_diversity_controller;
  import drhdc_pkg::*;

  localparam int DRAIN_CYCLES = 140;   // hop search can take up to 128 steps plus pipeline

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_t                 in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_t                out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  dual_radio_hop_diversity_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Controller model: settings, session state and expected headers
  // ---------------------------------------------------------------------------
  cfg_t        model_cfg;
  logic        cur_radio;
  logic [4:0]  cur_chan;
  logic        ann_radio;
  logic [4:0]  pos_a;
  logic [4:0]  pos_b;
  logic        descending;
  logic [7:0]  seq_no;
  logic [8:0]  fail_tally;
  logic [4:0]  chans_left_a;
  logic [4:0]  chans_left_b;
  logic        stopped;
  logic [31:0] ok_chan_a;
  logic [31:0] ok_chan_b;

  out_t expected_headers[$];

  int error_count    = 0;
  int requests_taken = 0;
  int results_seen   = 0;
  int flags_seen     = 0;
  int wraps_seen     = 0;
  int halts_seen     = 0;

  bit steady = 1'b0;   // no gaps and no stalls while set
  int stall_left = 0;
  int stall_pick;

  function automatic void restart_session();
    cur_radio    = 1'b0;
    cur_chan     = '0;
    ann_radio    = model_cfg.start_radio;
    pos_a        = '0;
    pos_b        = '0;
    descending   = 1'b0;
    seq_no       = '0;
    fail_tally   = '0;
    chans_left_a = model_cfg.top_channel;
    chans_left_b = model_cfg.top_channel;
    stopped      = 1'b0;
    ok_chan_a    = '1;
    ok_chan_b    = '1;
  endfunction

  // Radio A bounces between 0 and top; turning around costs one step.
  function automatic void sweep_radio_a();
    for (int n = 0; n < 128; n++) begin
      if (!descending) begin
        if (pos_a >= model_cfg.top_channel) descending = 1'b1;
        else pos_a++;
      end else begin
        if (pos_a == 0) descending = 1'b0;
        else pos_a--;
      end
      if (ok_chan_a[pos_a]) break;
    end
  endfunction

  function automatic void wrap_radio_b();
    for (int n = 0; n < 128; n++) begin
      if (pos_b >= model_cfg.top_channel) pos_b = '0;
      else pos_b++;
      if (ok_chan_b[pos_b]) break;
    end
  endfunction

  function automatic out_t step_controller(in_t req);
    out_t       hdr;
    logic       flagged;
    logic [4:0] flag_ch;
    logic       done;
    logic [8:0] tally;
    flagged = 1'b0;
    flag_ch = '0;
    done    = 1'b0;
    tally   = '0;
    if (!req.mode) begin
      restart_session();
    end else if (!stopped) begin
      if (req.ping_ok) begin
        cur_radio = ann_radio;
        cur_chan  = cur_radio ? pos_b : pos_a;
        if (model_cfg.diversity_on) ann_radio = ~cur_radio;
        if (model_cfg.hopping_on) begin
          if (!ann_radio) sweep_radio_a();
          else wrap_radio_b();
        end
      end else begin
        fail_tally = fail_tally + 9'd1;
        if (cur_chan != 0 && model_cfg.hopping_on) begin
          flagged = 1'b1;
          flag_ch = cur_chan;
          if (!cur_radio) begin
            ok_chan_a[cur_chan] = 1'b0;
            if (chans_left_a > 1) chans_left_a--;
            else stopped = 1'b1;
          end else begin
            ok_chan_b[cur_chan] = 1'b0;
            if (chans_left_b > 1) chans_left_b--;
            else stopped = 1'b1;
          end
        end
        // fall back to radio A, channel 0, unless pinned to radio A
        if (model_cfg.diversity_on || model_cfg.hopping_on || cur_radio) begin
          ann_radio = model_cfg.start_radio;
          cur_radio = 1'b0;
          cur_chan  = '0;
          pos_a     = '0;
          pos_b     = '0;
        end
      end
      if (seq_no != SEQ_LAST) begin
        seq_no++;
      end else begin
        done       = 1'b1;
        tally      = fail_tally;
        seq_no     = '0;
        fail_tally = '0;
      end
    end
    hdr.next_radio_code = ann_radio ? model_cfg.radio_b_code : model_cfg.radio_a_code;
    hdr.next_sequence   = seq_no;
    hdr.next_channel    = ann_radio ? pos_b : pos_a;
    hdr.tune_radio      = cur_radio;
    hdr.tune_channel    = cur_chan;
    hdr.channel_flagged = flagged;
    hdr.flagged_channel = flag_ch;
    hdr.tally_done      = done;
    hdr.tally_failures  = tally;
    hdr.exhausted       = stopped;
    return hdr;
  endfunction

  function automatic void check_header(out_t got);
    out_t       want;
    logic [8:0] w [10];
    logic [8:0] g [10];
    string      fname [10];
    results_seen++;
    if (expected_headers.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("result %0d arrived with nothing expected: %h", results_seen, got);
      return;
    end
    want = expected_headers.pop_front();
    fname = '{"next_radio_code", "next_sequence", "next_channel", "tune_radio", "tune_channel",
              "channel_flagged", "flagged_channel", "tally_done", "tally_failures", "exhausted"};
    w = '{want.next_radio_code, want.next_sequence, want.next_channel, want.tune_radio,
          want.tune_channel, want.channel_flagged, want.flagged_channel, want.tally_done,
          want.tally_failures, want.exhausted};
    g = '{got.next_radio_code, got.next_sequence, got.next_channel, got.tune_radio,
          got.tune_channel, got.channel_flagged, got.flagged_channel, got.tally_done,
          got.tally_failures, got.exhausted};
    for (int k = 0; k < 10; k++) begin
      if (g[k] !== w[k]) begin
        error_count++;
        if (error_count <= 10)
          $display("result %0d %s: expected %0d, got %0d", results_seen, fname[k], w[k], g[k]);
      end
    end
    if (want.channel_flagged) flags_seen++;
    if (want.tally_done) wraps_seen++;
    if (want.exhausted) halts_seen++;
  endfunction

  // Check results first, then log any newly accepted request.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_header(out_data);
      if (in_valid && !in_stall) begin
        requests_taken++;
        expected_headers.push_back(step_controller(in_data));
      end
    end
  end

  // Receiver: mostly ready, short stalls, now and then a long one.
  always @(posedge clk) begin
    if (steady) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 75) begin
        out_stall <= 1'b0;
      end else if (stall_pick < 95) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(logic mode, logic ping_ok);
    int gap;
    in_t req;
    gap = gap_cycles();
    req.mode    = mode;
    req.ping_ok = ping_ok;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // One edge first so the request taken at the calling edge is already queued.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_DIVERSITY: model_cfg.diversity_on = value[0];
      REG_HOPPING:   model_cfg.hopping_on   = value[0];
      REG_START:     model_cfg.start_radio  = value[0];
      REG_TOP:       model_cfg.top_channel  = value[4:0];
      REG_CODE_A:    model_cfg.radio_a_code = value[7:0];
      REG_CODE_B:    model_cfg.radio_b_code = value[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(logic div, logic hop, logic first_b, logic [4:0] top,
                                logic [7:0] code_a, logic [7:0] code_b);
    write_reg(REG_DIVERSITY, 32'(div));
    write_reg(REG_HOPPING, 32'(hop));
    write_reg(REG_START, 32'(first_b));
    write_reg(REG_TOP, 32'(top));
    write_reg(REG_CODE_A, 32'(code_a));
    write_reg(REG_CODE_B, 32'(code_b));
  endtask

  // Mostly ping reports; start requests sprinkled in at start_pct percent.
  task automatic send_pings(int count, int ok_pct, int start_pct);
    steady = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < start_pct)
        send_request(1'b0, 1'($urandom_range(0, 1)));
      else
        send_request(1'b1, 1'($urandom_range(0, 99) < ok_pct));
      if ($urandom_range(0, 49) == 0) steady = ~steady;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);
    send_request(1'b0, 1'b1);   // start request, ping_ok ignored
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);
    wait_idle();
  endtask

  // One usable channel: the first flagged failure halts the session.
  task automatic test_last_channel();
    write_settings(1'b0, 1'b1, 1'b0, 5'd1, 8'hFF, 8'h00);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);   // halted: nothing moves
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b1);
    wait_idle();
  endtask

  task automatic test_diversity_from_b();
    write_settings(1'b1, 1'b1, 1'b1, 5'd31, 8'h00, 8'hFF);
    send_request(1'b0, 1'b1);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b0);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b0);
    wait_idle();
  endtask

  // Lowering top mid-session leaves hop positions above the new range.
  task automatic test_top_lowered();
    write_settings(1'b1, 1'b1, 1'b0, 5'd25, 8'h5A, 8'hA5);
    send_request(1'b0, 1'b0);
    send_pings(60, 92, 0);
    wait_idle();
    write_reg(REG_TOP, 32'd3);
    send_pings(40, 70, 0);
    wait_idle();
  endtask

  // Hopping off never halts, so the sequence counter gets to wrap.
  task automatic test_tally_wrap();
    write_settings(1'b1, 1'b0, 1'b1, 5'd31, 8'($urandom), 8'($urandom));
    send_request(1'b0, 1'b1);
    send_pings(300, 60, 0);
    wait_idle();
  endtask

  task automatic test_random_settings();
    int         pick;
    logic [4:0] top;
    for (int phase = 0; phase < 6; phase++) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) top = 5'd1;
      else if (pick == 1) top = 5'd31;
      else top = 5'($urandom_range(1, 31));
      write_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) != 0),
                     1'($urandom_range(0, 1)), top,
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_request(1'b0, 1'($urandom_range(0, 1)));
      send_pings($urandom_range(50, 90), $urandom_range(40, 95), 2);
      wait_idle();
    end
  endtask

  initial begin
    model_cfg.diversity_on = 1'b0;
    model_cfg.hopping_on   = 1'b0;
    model_cfg.start_radio  = 1'b0;
    model_cfg.top_channel  = TOP_CHANNEL_RST;
    model_cfg.radio_a_code = RADIO_A_RST;
    model_cfg.radio_b_code = RADIO_B_RST;
    restart_session();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_last_channel();
    test_diversity_from_b();
    test_top_lowered();
    test_tally_wrap();
    test_random_settings();
    $display("Sent %0d requests and checked %0d results across several register settings.",
             requests_taken, results_seen);
    $display("Saw %0d flagged channels, %0d tally wraps and %0d halted-session results.",
             flags_seen, wraps_seen, halts_seen);
    if (error_count == 0 && expected_headers.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, expected_headers.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", expected_headers.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
